/* sv/lfc_pkg.sv */
// Shared types, codes and constants for the link failover controller.
// No dependencies; every other file refers to this package by scoped name.
`default_nettype none

package lfc_pkg;

    localparam int unsigned CntW = 32;
    localparam int unsigned CfgIdxW = 3;

    // Uptime credited to the active link per status check
    localparam logic [CntW-1:0] CHECK_PERIOD_MS = 32'd1000;

    typedef enum logic [1:0] {
        LINK_NONE  = 2'd0,
        LINK_WIFI  = 2'd1,
        LINK_WIRED = 2'd2
    } t_link;

    typedef enum logic [CfgIdxW-1:0] {
        REG_WIFI_ENABLE     = 3'd0,
        REG_WIRED_ENABLE    = 3'd1,
        REG_PRIMARY_IS_WIFI = 3'd2,
        REG_FAILOVER_ENABLE = 3'd3,
        REG_HEALTH_ENABLE   = 3'd4,
        REG_STABILITY_MS    = 3'd5,
        REG_RETRY_MS        = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic            wifi_enable;
        logic            wired_enable;
        logic            primary_is_wifi;
        logic            failover_enable;
        logic            health_enable;
        logic [CntW-1:0] stability_ms;
        logic [CntW-1:0] retry_ms;
    } t_cfg;

    typedef struct packed {
        logic [CntW-1:0] now_ms;
        logic            wifi_up;
        logic            wired_up;
        logic            app_healthy;
    } t_check;

    typedef struct packed {
        t_link           active_link;
        logic            on_backup;
        logic [CntW-1:0] failover_total;
        logic [CntW-1:0] last_failover_ms;
    } t_sel_next;

    typedef struct packed {
        logic [CntW-1:0] wifi_up_total;
        logic [CntW-1:0] wifi_down_total;
        logic [CntW-1:0] wired_up_total;
        logic [CntW-1:0] wired_down_total;
        logic [CntW-1:0] wifi_uptime_ms;
        logic [CntW-1:0] wired_uptime_ms;
    } t_stat_next;

    function automatic logic link_up(t_link link, logic wifi_up, logic wired_up);
        logic up;
        unique case (link)
            LINK_WIFI:  up = wifi_up;
            LINK_WIRED: up = wired_up;
            default:    up = 1'b0;
        endcase
        return up;
    endfunction

endpackage

`default_nettype wire

/* sv/lfc_if.sv */
// Valid/ready channel interfaces: status check input, result output, register writes.
// Depends on lfc_pkg for widths.
`default_nettype none

interface lfc_check_if;
    logic                      valid;
    logic                      ready;
    logic [lfc_pkg::CntW-1:0]  now_ms;
    logic                      wifi_up;
    logic                      wired_up;
    logic                      app_healthy;

    modport source (output valid, output now_ms, output wifi_up, output wired_up,
                    output app_healthy, input ready);
    modport sink   (input valid, input now_ms, input wifi_up, input wired_up,
                    input app_healthy, output ready);
endinterface

interface lfc_result_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                active_link;
    logic                      on_backup;
    logic                      switched;
    logic [lfc_pkg::CntW-1:0]  failover_total;
    logic [lfc_pkg::CntW-1:0]  last_failover_ms;
    logic [lfc_pkg::CntW-1:0]  wifi_up_total;
    logic [lfc_pkg::CntW-1:0]  wifi_down_total;
    logic [lfc_pkg::CntW-1:0]  wired_up_total;
    logic [lfc_pkg::CntW-1:0]  wired_down_total;
    logic [lfc_pkg::CntW-1:0]  wifi_uptime_ms;
    logic [lfc_pkg::CntW-1:0]  wired_uptime_ms;

    modport source (output valid, output active_link, output on_backup, output switched,
                    output failover_total, output last_failover_ms, output wifi_up_total,
                    output wifi_down_total, output wired_up_total, output wired_down_total,
                    output wifi_uptime_ms, output wired_uptime_ms, input ready);
    modport sink   (input valid, input active_link, input on_backup, input switched,
                    input failover_total, input last_failover_ms, input wifi_up_total,
                    input wifi_down_total, input wired_up_total, input wired_down_total,
                    input wifi_uptime_ms, input wired_uptime_ms, output ready);
endinterface

interface lfc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lfc_pkg::CfgIdxW-1:0]  index;
    logic [lfc_pkg::CntW-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/lfc_stats.sv */
// Per-link edge counters and uptime accumulators.
// Depends on lfc_pkg.
`default_nettype none

module lfc_stats (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire lfc_pkg::t_cfg       i_cfg,
    input  wire lfc_pkg::t_check     i_check,
    input  wire lfc_pkg::t_link      i_active_link,
    output lfc_pkg::t_stat_next      o_next
);

    logic               r_wifi_prev;
    logic               r_wired_prev;
    lfc_pkg::t_stat_next r_stat;
    logic               n_wifi_prev;
    logic               n_wired_prev;
    lfc_pkg::t_stat_next n_stat;

    always_comb begin
        n_stat       = r_stat;
        n_wifi_prev  = r_wifi_prev;
        n_wired_prev = r_wired_prev;

        if (i_cfg.wifi_enable) begin
            n_wifi_prev = i_check.wifi_up;
            if (i_check.wifi_up && !r_wifi_prev) begin
                n_stat.wifi_up_total = r_stat.wifi_up_total + 32'd1;
            end else if (!i_check.wifi_up && r_wifi_prev) begin
                n_stat.wifi_down_total = r_stat.wifi_down_total + 32'd1;
            end
        end
        if (i_cfg.wired_enable) begin
            n_wired_prev = i_check.wired_up;
            if (i_check.wired_up && !r_wired_prev) begin
                n_stat.wired_up_total = r_stat.wired_up_total + 32'd1;
            end else if (!i_check.wired_up && r_wired_prev) begin
                n_stat.wired_down_total = r_stat.wired_down_total + 32'd1;
            end
        end

        // credit the link that was active when the check arrived
        unique case (i_active_link)
            lfc_pkg::LINK_WIFI:
                n_stat.wifi_uptime_ms = r_stat.wifi_uptime_ms + lfc_pkg::CHECK_PERIOD_MS;
            lfc_pkg::LINK_WIRED:
                n_stat.wired_uptime_ms = r_stat.wired_uptime_ms + lfc_pkg::CHECK_PERIOD_MS;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wifi_prev  <= 1'b0;
            r_wired_prev <= 1'b0;
            r_stat       <= '0;
        end else if (i_advance) begin
            r_wifi_prev  <= n_wifi_prev;
            r_wired_prev <= n_wired_prev;
            r_stat       <= n_stat;
        end
    end

    assign o_next = n_stat;

endmodule

`default_nettype wire

/* sv/lfc_select.sv */
// Active link selection: failover, revert hold and retry pacing.
// Depends on lfc_pkg.
`default_nettype none

module lfc_select (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire lfc_pkg::t_cfg       i_cfg,
    input  wire lfc_pkg::t_check     i_check,
    output lfc_pkg::t_link           o_active_link,
    output lfc_pkg::t_sel_next       o_next
);

    lfc_pkg::t_sel_next        r_sel;
    logic                      r_hold_valid;
    logic [lfc_pkg::CntW-1:0]  r_hold_start;
    logic [lfc_pkg::CntW-1:0]  r_last_retry;
    lfc_pkg::t_sel_next        n_sel;
    logic                      n_hold_valid;
    logic [lfc_pkg::CntW-1:0]  n_hold_start;
    logic [lfc_pkg::CntW-1:0]  n_last_retry;

    lfc_pkg::t_link            prim;
    lfc_pkg::t_link            sec;
    logic                      prim_ok;
    logic                      sec_ok;
    logic                      active_lost;
    logic                      health_trip;
    logic                      hold_done;
    logic                      retry_due;

    always_comb begin
        if (i_cfg.primary_is_wifi) begin
            prim = i_cfg.wifi_enable  ? lfc_pkg::LINK_WIFI  : lfc_pkg::LINK_NONE;
            sec  = i_cfg.wired_enable ? lfc_pkg::LINK_WIRED : lfc_pkg::LINK_NONE;
        end else begin
            prim = i_cfg.wired_enable ? lfc_pkg::LINK_WIRED : lfc_pkg::LINK_NONE;
            sec  = i_cfg.wifi_enable  ? lfc_pkg::LINK_WIFI  : lfc_pkg::LINK_NONE;
        end
        prim_ok = lfc_pkg::link_up(prim, i_check.wifi_up, i_check.wired_up);
        sec_ok  = lfc_pkg::link_up(sec, i_check.wifi_up, i_check.wired_up);

        active_lost = (r_sel.active_link != lfc_pkg::LINK_NONE) &&
                      !lfc_pkg::link_up(r_sel.active_link, i_check.wifi_up, i_check.wired_up);
        health_trip = i_cfg.health_enable && (prim != lfc_pkg::LINK_NONE) &&
                      (r_sel.active_link == prim) && !i_check.app_healthy;
        hold_done   = (i_check.now_ms - r_hold_start) >= i_cfg.stability_ms;
        retry_due   = (i_check.now_ms - r_last_retry) >= i_cfg.retry_ms;

        n_sel        = r_sel;
        n_hold_valid = r_hold_valid;
        n_hold_start = r_hold_start;
        n_last_retry = r_last_retry;

        if (i_cfg.failover_enable) begin
            priority if (active_lost) begin
                if (r_sel.active_link == prim && sec_ok) begin
                    n_sel.active_link      = sec;
                    n_sel.on_backup        = 1'b1;
                    n_sel.failover_total   = r_sel.failover_total + 32'd1;
                    n_sel.last_failover_ms = i_check.now_ms;
                end else if (r_sel.active_link == sec && prim_ok) begin
                    n_sel.active_link = prim;
                    n_sel.on_backup   = 1'b0;
                end else begin
                    n_sel.active_link = lfc_pkg::LINK_NONE;
                end
                n_hold_valid = 1'b0;
                n_hold_start = '0;
            end else if (health_trip) begin
                // stay put when the secondary cannot take over
                if (sec_ok) begin
                    n_sel.active_link      = sec;
                    n_sel.on_backup        = 1'b1;
                    n_sel.failover_total   = r_sel.failover_total + 32'd1;
                    n_sel.last_failover_ms = i_check.now_ms;
                    n_hold_valid           = 1'b0;
                    n_hold_start           = '0;
                end
            end else begin
                if (r_sel.on_backup && prim_ok) begin
                    if (!r_hold_valid) begin
                        n_hold_start = i_check.now_ms;
                        n_hold_valid = 1'b1;
                    end else if (hold_done) begin
                        n_sel.active_link = prim;
                        n_sel.on_backup   = 1'b0;
                        n_hold_valid      = 1'b0;
                        n_hold_start      = '0;
                    end
                end else begin
                    n_hold_valid = 1'b0;
                    n_hold_start = '0;
                end

                // a revert never leaves the link at none, so the retry sees the old selection
                if (n_sel.active_link == lfc_pkg::LINK_NONE && retry_due) begin
                    n_last_retry = i_check.now_ms;
                    if (prim_ok) begin
                        n_sel.active_link = prim;
                    end else if (sec_ok) begin
                        n_sel.active_link = sec;
                        n_sel.on_backup   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel        <= '{active_link: lfc_pkg::LINK_NONE, on_backup: 1'b0,
                              failover_total: '0, last_failover_ms: '0};
            r_hold_valid <= 1'b0;
            r_hold_start <= '0;
            r_last_retry <= '0;
        end else if (i_advance) begin
            r_sel        <= n_sel;
            r_hold_valid <= n_hold_valid;
            r_hold_start <= n_hold_start;
            r_last_retry <= n_last_retry;
        end
    end

    assign o_active_link = r_sel.active_link;
    assign o_next        = n_sel;

endmodule

`default_nettype wire

/* sv/link_failover_controller.sv */
// Link failover controller top level: register file, check register, result register.
// Depends on lfc_pkg, lfc_if, lfc_stats and lfc_select.
// Each accepted check beat passes the check register, then the result register.
// Throughput: one check per cycle while the sink is ready; set by the single
//   evaluation stage between the check register and the result register.
// Reset (i_rst_n low at a clock edge): registers return to their documented
//   defaults, all counters and link state clear, no beat is held.
`default_nettype none

module link_failover_controller (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lfc_check_if.sink     i_check,
    lfc_cfg_if.sink       i_cfg,
    lfc_result_if.source  o_result
);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write only while the block is idle (the
    // block does not enforce it); writes apply on the next check without ordering logic.
    // ------------------------------------------------------------------
    lfc_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{wifi_enable: 1'b1, wired_enable: 1'b1, primary_is_wifi: 1'b0,
                       failover_enable: 1'b1, health_enable: 1'b1,
                       stability_ms: 32'd30000, retry_ms: 32'd5000};
        end else if (i_cfg.valid) begin
            unique case (lfc_pkg::t_reg_idx'(i_cfg.index))
                lfc_pkg::REG_WIFI_ENABLE:     r_cfg.wifi_enable     <= i_cfg.data[0];
                lfc_pkg::REG_WIRED_ENABLE:    r_cfg.wired_enable    <= i_cfg.data[0];
                lfc_pkg::REG_PRIMARY_IS_WIFI: r_cfg.primary_is_wifi <= i_cfg.data[0];
                lfc_pkg::REG_FAILOVER_ENABLE: r_cfg.failover_enable <= i_cfg.data[0];
                lfc_pkg::REG_HEALTH_ENABLE:   r_cfg.health_enable   <= i_cfg.data[0];
                lfc_pkg::REG_STABILITY_MS:    r_cfg.stability_ms    <= i_cfg.data;
                lfc_pkg::REG_RETRY_MS:        r_cfg.retry_ms        <= i_cfg.data;
                default: ; // drop writes past the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. A check sits in the check register until the
    // result register can take its outcome; the state machines advance
    // on that same edge, so checks are evaluated strictly in order.
    // ------------------------------------------------------------------
    logic            r_in_valid;
    lfc_pkg::t_check r_in;
    logic            r_out_valid;
    logic            advance;

    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_check.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_check.ready) begin
            r_in_valid <= i_check.valid;
        end
    end

    // payload needs no reset; its valid bit guards it
    always_ff @(posedge i_clk) begin
        if (i_check.valid && i_check.ready) begin
            r_in <= '{now_ms: i_check.now_ms, wifi_up: i_check.wifi_up,
                      wired_up: i_check.wired_up, app_healthy: i_check.app_healthy};
        end
    end

    // ------------------------------------------------------------------
    // Evaluation: link selection and statistics, both from the held check.
    // Uptime is credited to the link active before this check.
    // ------------------------------------------------------------------
    lfc_pkg::t_link      active_now;
    lfc_pkg::t_sel_next  sel_next;
    lfc_pkg::t_stat_next stat_next;

    lfc_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_cfg         (r_cfg),
        .i_check       (r_in),
        .o_active_link (active_now),
        .o_next        (sel_next)
    );

    lfc_stats u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_cfg         (r_cfg),
        .i_check       (r_in),
        .i_active_link (active_now),
        .o_next        (stat_next)
    );

    // ------------------------------------------------------------------
    // Result register: load on advance, hold while the sink stalls.
    // ------------------------------------------------------------------
    lfc_pkg::t_sel_next  r_res_sel;
    lfc_pkg::t_stat_next r_res_stat;
    logic                r_res_switched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_sel      <= sel_next;
            r_res_stat     <= stat_next;
            r_res_switched <= (sel_next.active_link != active_now);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.active_link      = r_res_sel.active_link;
    assign o_result.on_backup        = r_res_sel.on_backup;
    assign o_result.switched         = r_res_switched;
    assign o_result.failover_total   = r_res_sel.failover_total;
    assign o_result.last_failover_ms = r_res_sel.last_failover_ms;
    assign o_result.wifi_up_total    = r_res_stat.wifi_up_total;
    assign o_result.wifi_down_total  = r_res_stat.wifi_down_total;
    assign o_result.wired_up_total   = r_res_stat.wired_up_total;
    assign o_result.wired_down_total = r_res_stat.wired_down_total;
    assign o_result.wifi_uptime_ms   = r_res_stat.wifi_uptime_ms;
    assign o_result.wired_uptime_ms  = r_res_stat.wired_uptime_ms;

endmodule

`default_nettype wire
